>>> design/qccf_pkg.sv
// Shared types and constants for the Q31 cross-correlation unit.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package qccf_pkg;

    localparam int ACTION_W    = 2;
    localparam int POS_W       = 10;
    localparam int SAMPLE_W    = 32;
    localparam int LAG_W       = 11;
    localparam int LEN_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int COUNT_W     = 12;
    localparam int CALC_W      = 13;

    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_action ACT_LOAD_A  = 2'd0;
    localparam t_action ACT_LOAD_B  = 2'd1;
    localparam t_action ACT_COMPUTE = 2'd2;

    localparam t_cfg_idx CFG_A_LEN = 1'b0;
    localparam t_cfg_idx CFG_B_LEN = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the lag of an accepted compute request
        logic write_a;  // store the sample of an accepted load into A
        logic write_b;  // store the sample of an accepted load into B
        logic setup;    // work out the index window and clear the accumulator
        logic issue;    // read one pair of samples and advance the addresses
        logic out_load; // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic left_zero;  // no more sample pairs to read
        logic pipe_empty; // no product in flight
        logic out_free;   // output register can take a result now
    } t_dp_status;

endpackage

>>> design/qccf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qccf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/qccf_ctrl.sv
// Controller state machine for the Q31 cross-correlation unit.
// Depends on qccf_pkg; drives the datapath by command and status structs.
module qccf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  qccf_pkg::t_action    i_action,
    output logic                 o_in_ready,
    input  qccf_pkg::t_dp_status i_status,
    output qccf_pkg::t_dp_cmd    o_cmd
);
    import qccf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   w_accept;

    assign w_accept   = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state    = r_state;
        n_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                n_in_ready    = 1'b1;
                o_cmd.write_a = w_accept && (i_action == ACT_LOAD_A);
                o_cmd.write_b = w_accept && (i_action == ACT_LOAD_B);
                o_cmd.capture = w_accept && (i_action == ACT_COMPUTE);
                if (w_accept && (i_action == ACT_COMPUTE)) begin
                    n_state    = ST_SETUP;
                    n_in_ready = 1'b0;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.issue = !i_status.left_zero;
                if (i_status.left_zero) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait here only while an earlier result still sits unread.
                o_cmd.out_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state    = ST_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

endmodule

>>> design/qccf_dp.sv
// Datapath of the Q31 cross-correlation unit: length registers, sample RAMs,
// index window, multiply-accumulate pipeline and output register.
// Depends on qccf_pkg and qccf_ram.
module qccf_dp #(
    parameter int MAX_LEN = 1024,
    parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qccf_pkg::t_dp_cmd                    i_cmd,
    output qccf_pkg::t_dp_status                 o_status,
    input  logic                                 i_cfg_valid,
    input  qccf_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [qccf_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic [qccf_pkg::POS_W-1:0]           i_position,
    input  logic signed [qccf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [qccf_pkg::LAG_W-1:0]           i_lag,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [qccf_pkg::SAMPLE_W-1:0] o_correlation,
    output logic [qccf_pkg::LAG_W-1:0]           o_lag_echo,
    output logic                                 o_bad_lag
);
    import qccf_pkg::*;

    logic [LEN_W-1:0]          r_len_a;
    logic [LEN_W-1:0]          r_len_b;
    logic [LAG_W-1:0]          r_lag;
    logic                      r_bad;
    logic [COUNT_W-1:0]        r_left;
    logic [AW-1:0]             r_addr_a;
    logic [AW-1:0]             r_addr_b;
    logic                      r_v1;
    logic                      r_v2;
    logic signed [63:0]        r_prod;
    logic [SAMPLE_W-1:0]       r_acc;
    logic                      r_out_valid;
    logic [SAMPLE_W-1:0]       r_out_corr;
    logic [LAG_W-1:0]          r_out_lag;
    logic                      r_out_bad;

    logic [LEN_W-1:0]          w_la;
    logic [LEN_W-1:0]          w_lb;
    logic signed [CALC_W-1:0]  w_la_s;
    logic signed [CALC_W-1:0]  w_lb_s;
    logic signed [CALC_W-1:0]  w_lag_s;
    logic signed [CALC_W-1:0]  w_lo_raw;
    logic signed [CALC_W-1:0]  w_lo;
    logic signed [CALC_W-1:0]  w_hi;
    logic signed [CALC_W-1:0]  w_ib_start;
    logic                      w_bad;
    logic [COUNT_W-1:0]        w_count;
    logic                      w_pos_ok;
    logic [AW-1:0]             w_wr_addr;
    logic [SAMPLE_W-1:0]       w_rd_a;
    logic [SAMPLE_W-1:0]       w_rd_b;

    // Lengths above the sequence storage saturate to its depth.
    assign w_la = (32'(r_len_a) > MAX_LEN) ? LEN_W'(MAX_LEN) : r_len_a;
    assign w_lb = (32'(r_len_b) > MAX_LEN) ? LEN_W'(MAX_LEN) : r_len_b;

    assign w_la_s  = $signed(CALC_W'(w_la));
    assign w_lb_s  = $signed(CALC_W'(w_lb));
    assign w_lag_s = $signed(CALC_W'(r_lag));

    // Window of A indices that meet a valid B index at this lag.
    assign w_lo_raw   = w_lag_s - w_lb_s + CALC_W'(1);
    assign w_lo       = (w_lo_raw < 0) ? '0 : w_lo_raw;
    // An empty A sequence gives a last index of minus one, so this compare is signed.
    assign w_hi       = (w_lag_s > $signed(w_la_s - CALC_W'(1))) ? (w_la_s - CALC_W'(1))
                                                                 : w_lag_s;
    assign w_ib_start = w_lo - w_lag_s + w_lb_s - CALC_W'(1);
    assign w_bad      = (w_lag_s + CALC_W'(1)) >= (w_la_s + w_lb_s);
    assign w_count    = (w_bad || (w_hi < w_lo)) ? '0
                                                 : COUNT_W'(w_hi - w_lo + CALC_W'(1));

    assign w_pos_ok  = 32'(i_position) < MAX_LEN;
    assign w_wr_addr = AW'(i_position);

    qccf_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_LEN),
        .AW   (AW)
    ) u_ram_a (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.write_a && w_pos_ok),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(i_sample),
        .i_rd_en  (i_cmd.issue),
        .i_rd_addr(r_addr_a),
        .o_rd_data(w_rd_a)
    );

    qccf_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_LEN),
        .AW   (AW)
    ) u_ram_b (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.write_b && w_pos_ok),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(i_sample),
        .i_rd_en  (i_cmd.issue),
        .i_rd_addr(r_addr_b),
        .o_rd_data(w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= LEN_W'(1);
            r_len_b     <= LEN_W'(1);
            r_left      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_A_LEN)) begin
                r_len_a <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_B_LEN)) begin
                r_len_b <= i_cfg_data;
            end
            if (i_cmd.setup) begin
                r_left <= w_count;
            end else if (i_cmd.issue) begin
                r_left <= r_left - COUNT_W'(1);
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lag <= i_lag;
        end
        if (i_cmd.setup) begin
            r_addr_a <= AW'(w_lo);
            r_addr_b <= AW'(w_ib_start);
            r_bad    <= w_bad;
        end else if (i_cmd.issue) begin
            r_addr_a <= r_addr_a + AW'(1);
            r_addr_b <= r_addr_b + AW'(1);
        end
        if (r_v1) begin
            r_prod <= $signed(w_rd_a) * $signed(w_rd_b);
        end
        // The high word of each product adds into a wrapping accumulator.
        if (i_cmd.setup) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + r_prod[63:32];
        end
        if (i_cmd.out_load) begin
            r_out_corr <= {r_acc[SAMPLE_W-2:0], 1'b0};
            r_out_lag  <= r_lag;
            r_out_bad  <= r_bad;
        end
    end

    assign o_status.left_zero  = (r_left == '0);
    assign o_status.pipe_empty = !r_v1 && !r_v2;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_correlation = $signed(r_out_corr);
    assign o_lag_echo    = r_out_lag;
    assign o_bad_lag     = r_out_bad;

endmodule

>>> design/q31_cross_correlation_fast_unit.sv
// A compute request for lag k returns one Q31 correlation value; once it is taken the input
// stays not ready while the one multiply-accumulate pipeline, which reads one sample of A and
// one of B per cycle, works through the N overlapping samples at that lag (at most
// min(a_length, b_length), so up to MAX_LEN); it stays not ready longer while an earlier
// result still waits on the output. A load request gives no result. A lag at or beyond
// a_length + b_length - 1 returns zero with bad_lag set. New requests are taken while an
// earlier result waits on the output. Lengths are to be written through the configuration
// port only while the unit is idle; the block itself does not enforce it. There is no
// clearing pass.
// Depends on qccf_pkg, qccf_ctrl, qccf_dp and qccf_ram.
module q31_cross_correlation_fast_unit #(
    parameter int MAX_LEN = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [9:0] position, [41:10] sample, [52:42] lag, [55:53] zero
    input  logic [qccf_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // [1:0] action
    input  logic [qccf_pkg::ACTION_W-1:0]          s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [31:0] correlation, [42:32] lag_echo, [47:43] zero
    output logic [qccf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] bad_lag
    output logic                                   m_axis_tuser,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  qccf_pkg::t_cfg_idx                     i_cfg_index,
    input  logic [qccf_pkg::LEN_W-1:0]             i_cfg_data
);
    import qccf_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;
    logic signed [SAMPLE_W-1:0] w_corr;
    logic [LAG_W-1:0]           w_lag_echo;
    logic                       w_bad_lag;

    assign o_cfg_ready = 1'b1;

    qccf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    qccf_dp #(
        .MAX_LEN(MAX_LEN),
        .AW     (AW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_position   (s_axis_tdata[POS_W-1:0]),
        .i_sample     ($signed(s_axis_tdata[POS_W+SAMPLE_W-1:POS_W])),
        .i_lag        (s_axis_tdata[POS_W+SAMPLE_W+LAG_W-1:POS_W+SAMPLE_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_correlation(w_corr),
        .o_lag_echo   (w_lag_echo),
        .o_bad_lag    (w_bad_lag)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-SAMPLE_W-LAG_W)'(0), w_lag_echo, w_corr};
    assign m_axis_tuser = w_bad_lag;

endmodule

>>> design/qccf_checker.sv
// Port-level checker for the Q31 cross-correlation unit, bound to the top level.
// Depends on qccf_pkg and q31_cross_correlation_fast_unit.
module qccf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [qccf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic [qccf_pkg::ACTION_W-1:0]      s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [qccf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                               m_axis_tuser
);
    import qccf_pkg::*;

    // A held result keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A bad lag always reports a zero correlation.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[SAMPLE_W-1:0] == '0)
        else $error("bad lag with nonzero correlation");

    // Once a compute request is taken, no new request is taken in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_COMPUTE) |=> !s_axis_tready)
        else $error("request taken while a compute is in progress");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

endmodule

bind q31_cross_correlation_fast_unit qccf_checker u_qccf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
